### sv/cru_pkg.sv
// Package for the circle rasterizer unit: screen and radius defaults,
// command codes and the mirror point count. No dependencies.
package cru_pkg;

    // Default screen size and radius limit
    localparam int unsigned SCREEN_WIDTH_DEF  = 128;
    localparam int unsigned SCREEN_HEIGHT_DEF = 64;
    localparam int unsigned MAX_RADIUS_DEF    = 127;

    // Input beat kind, carried on tuser
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    // Index of the last of the eight mirror points
    localparam logic [2:0] MIRROR_LAST = 3'd7;

    // Midpoint start terms
    localparam logic [8:0]  STEP_A_INIT = 9'd3;
    localparam logic [9:0]  STEP_B_BASE = 10'd2;
    localparam logic [10:0] DECISION_BASE = 11'd1;
    localparam logic [8:0]  STEP_INC = 9'd2;

endpackage

### sv/circle_rasterizer_unit.sv
// Circle rasterizer unit: midpoint circle pixel generator, eight-way mirror.
// Depends on cru_pkg.
//
//  channel  | dir | tdata (low bit up)                          | tuser      | tlast
//  s_axis   | in  | center_x, center_y, radius, pixel_op, pad   | command    | -
//  m_axis   | out | pixel_x, pixel_y, op_out, pad               | on_screen  | last_pixel
//
// One beat is taken every cycle while s_axis_tready is high; an advance
// beat's pixel appears in the output register in the next cycle. Cycle time is set
// by the mirror add feeding the screen compare and the three-term decision sum.
// Synchronous active-low reset clears the busy flag, the mirror index, the offsets
// and output valid.
// s_axis_tready drops only while a held output beat is not taken by m_axis.
module circle_rasterizer_unit
    import cru_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int unsigned MAX_RADIUS    = MAX_RADIUS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // center_x[7:0], center_y[15:8], radius[22:16],
                                        // pixel_op[24:23], zero pad
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // pixel_x[7:0], pixel_y[15:8], op_out[17:16], zero pad
    output logic        m_axis_tuser,   // on_screen
    output logic        m_axis_tlast    // last_pixel
);

    // Circle state
    logic        r_busy, n_busy;
    logic [7:0]  r_cx, n_cx;
    logic [7:0]  r_cy, n_cy;
    logic [1:0]  r_op, n_op;
    logic [6:0]  r_a, n_a;
    logic [6:0]  r_b, n_b;
    logic [10:0] r_decision, n_decision;
    logic [8:0]  r_step_a, n_step_a;
    logic [9:0]  r_step_b, n_step_b;
    logic [2:0]  r_mirror, n_mirror;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_px, n_px;
    logic [7:0]  r_py, n_py;
    logic        r_on_screen, n_on_screen;
    logic [1:0]  r_op_out, n_op_out;
    logic        r_last, n_last;

    // Input field unpacking
    logic        w_accept;
    t_cmd        w_cmd;
    logic [7:0]  w_in_cx;
    logic [7:0]  w_in_cy;
    logic [6:0]  w_in_radius;
    logic [6:0]  w_radius;
    logic [1:0]  w_in_op;

    // Datapath helpers
    logic [7:0]  w_a8;
    logic [7:0]  w_b8;
    logic [7:0]  w_px;
    logic [7:0]  w_py;
    logic [11:0] w_d_ext;
    logic [11:0] w_sa_ext;
    logic [11:0] w_sb_ext;
    logic [11:0] w_d_neg;
    logic [11:0] w_d_pos;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = t_cmd'(s_axis_tuser);
    assign w_in_cx       = s_axis_tdata[7:0];
    assign w_in_cy       = s_axis_tdata[15:8];
    assign w_in_radius   = s_axis_tdata[22:16];
    assign w_in_op       = s_axis_tdata[24:23];

    // Radius saturation
    assign w_radius = (w_in_radius > 7'(MAX_RADIUS)) ? 7'(MAX_RADIUS) : w_in_radius;

    // Mirror point select
    assign w_a8 = {1'b0, r_a};
    assign w_b8 = {1'b0, r_b};
    always_comb begin
        case (r_mirror)
            3'd0: begin w_px = r_cx + w_b8; w_py = r_cy + w_a8; end
            3'd1: begin w_px = r_cx + w_a8; w_py = r_cy + w_b8; end
            3'd2: begin w_px = r_cx - w_a8; w_py = r_cy + w_b8; end
            3'd3: begin w_px = r_cx - w_b8; w_py = r_cy + w_a8; end
            3'd4: begin w_px = r_cx - w_b8; w_py = r_cy - w_a8; end
            3'd5: begin w_px = r_cx - w_a8; w_py = r_cy - w_b8; end
            3'd6: begin w_px = r_cx + w_a8; w_py = r_cy - w_b8; end
            default: begin w_px = r_cx + w_b8; w_py = r_cy - w_a8; end
        endcase
    end

    // Midpoint decision candidates, one bit of headroom
    assign w_d_ext  = {r_decision[10], r_decision};
    assign w_sa_ext = {3'b000, r_step_a};
    assign w_sb_ext = {{2{r_step_b[9]}}, r_step_b};
    assign w_d_neg  = w_d_ext + w_sa_ext;
    assign w_d_pos  = w_d_ext + w_sa_ext + w_sb_ext;

    // Next state and output beat
    always_comb begin
        n_busy      = r_busy;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_decision  = r_decision;
        n_step_a    = r_step_a;
        n_step_b    = r_step_b;
        n_mirror    = r_mirror;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_px        = r_px;
        n_py        = r_py;
        n_on_screen = r_on_screen;
        n_op_out    = r_op_out;
        n_last      = r_last;

        if (w_accept) begin
            if (w_cmd == CMD_START) begin
                n_busy     = 1'b1;
                n_cx       = w_in_cx;
                n_cy       = w_in_cy;
                n_op       = w_in_op;
                n_a        = '0;
                n_b        = w_radius;
                n_step_a   = STEP_A_INIT;
                n_step_b   = STEP_B_BASE - {2'b00, w_radius, 1'b0};
                n_decision = DECISION_BASE - {4'b0000, w_radius};
                n_mirror   = '0;
            end else if (r_busy) begin
                n_out_valid = 1'b1;
                n_px        = w_px;
                n_py        = w_py;
                n_on_screen = ({1'b0, w_px} < 9'(SCREEN_WIDTH)) &&
                              ({1'b0, w_py} < 9'(SCREEN_HEIGHT));
                n_op_out    = r_op;
                n_last      = 1'b0;
                n_mirror    = r_mirror + 3'd1;
                if (r_mirror == MIRROR_LAST) begin
                    if (r_a < r_b) begin
                        // one midpoint step
                        n_a      = r_a + 7'd1;
                        n_step_a = r_step_a + STEP_INC;
                        if (r_decision[10]) begin
                            n_decision = w_d_neg[10:0];
                        end else begin
                            n_decision = w_d_pos[10:0];
                            n_step_b   = r_step_b + {1'b0, STEP_INC};
                            n_b        = r_b - 7'd1;
                        end
                    end else begin
                        n_last = 1'b1;
                        n_busy = 1'b0;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mirror    <= '0;
            r_a         <= '0;
            r_b         <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_mirror    <= n_mirror;
            r_a         <= n_a;
            r_b         <= n_b;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_op        <= n_op;
        r_decision  <= n_decision;
        r_step_a    <= n_step_a;
        r_step_b    <= n_step_b;
        r_px        <= n_px;
        r_py        <= n_py;
        r_on_screen <= n_on_screen;
        r_op_out    <= n_op_out;
        r_last      <= n_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_op_out, r_py, r_px};
    assign m_axis_tuser  = r_on_screen;
    assign m_axis_tlast  = r_last;

endmodule

### verif/cru_checker.sv
// Scoreboard for the circle rasterizer unit: watches both stream channels,
// predicts each pixel beat with its own midpoint circle model and compares.
// Depends on cru_pkg.
module cru_checker
    import cru_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int unsigned MAX_RADIUS    = MAX_RADIUS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // center_x, center_y, radius, pixel_op, pad
    input  logic        i_s_tuser,    // command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // pixel_x, pixel_y, op_out, pad
    input  logic        i_m_tuser,    // on_screen
    input  logic        i_m_tlast,    // last_pixel
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic       visible;
        logic [1:0] op;
        logic       last_px;
    } t_pixel;

    // Model of the generator state
    logic               drawing;
    logic [7:0]         ctr_col;
    logic [7:0]         ctr_row;
    logic [1:0]         op_held;
    logic [6:0]         off_a;
    logic [6:0]         off_b;
    logic signed [10:0] err_term;
    logic [8:0]         err_inc_a;
    logic signed [9:0]  err_inc_b;
    logic [2:0]         octant;

    t_pixel pixels_due[$];
    int     mismatches = 0;

    // Apply one accepted input beat; queue the pixel it yields, if any
    task automatic rasterize_beat(input t_cmd cmd, input logic [31:0] data);
        logic [6:0] rad;
        t_pixel     pix;
        if (cmd == CMD_START) begin
            rad = data[22:16];
            if (int'(rad) > int'(MAX_RADIUS))
                rad = 7'(MAX_RADIUS);
            ctr_col   = data[7:0];
            ctr_row   = data[15:8];
            op_held   = data[24:23];
            off_a     = '0;
            off_b     = rad;
            err_inc_a = 9'd3;
            err_inc_b = 10'(2 - 2 * int'(rad));
            err_term  = 11'(1 - int'(rad));
            octant    = '0;
            drawing   = 1'b1;
        end else if (drawing) begin
            // eight-way mirror, coordinates wrap to 8 bits
            case (octant)
                3'd0: begin pix.col = ctr_col + off_b; pix.row = ctr_row + off_a; end
                3'd1: begin pix.col = ctr_col + off_a; pix.row = ctr_row + off_b; end
                3'd2: begin pix.col = ctr_col - off_a; pix.row = ctr_row + off_b; end
                3'd3: begin pix.col = ctr_col - off_b; pix.row = ctr_row + off_a; end
                3'd4: begin pix.col = ctr_col - off_b; pix.row = ctr_row - off_a; end
                3'd5: begin pix.col = ctr_col - off_a; pix.row = ctr_row - off_b; end
                3'd6: begin pix.col = ctr_col + off_a; pix.row = ctr_row - off_b; end
                default: begin pix.col = ctr_col + off_b; pix.row = ctr_row - off_a; end
            endcase
            pix.last_px = 1'b0;
            if (octant == MIRROR_LAST) begin
                if (off_a < off_b) begin
                    // midpoint step: b moves only when the error is not negative
                    if (err_term < 0) begin
                        err_term = 11'(int'(err_term) + int'(err_inc_a));
                    end else begin
                        err_term = 11'(int'(err_term) + int'(err_inc_a) + int'(err_inc_b));
                        err_inc_b = err_inc_b + 10'sd2;
                        off_b = off_b - 7'd1;
                    end
                    err_inc_a = err_inc_a + 9'd2;
                    off_a = off_a + 7'd1;
                end else begin
                    pix.last_px = 1'b1;
                    drawing = 1'b0;
                end
                octant = '0;
            end else begin
                octant = octant + 3'd1;
            end
            pix.visible = (pix.col < SCREEN_WIDTH) && (pix.row < SCREEN_HEIGHT);
            pix.op = op_held;
            pixels_due.push_back(pix);
        end
    endtask

    // Compare output beats first, then predict from the input beat
    always @(posedge i_clk) begin : scoreboard
        t_pixel seen;
        t_pixel due;
        if (!i_rst_n) begin
            drawing   = 1'b0;
            ctr_col   = '0;
            ctr_row   = '0;
            op_held   = '0;
            off_a     = '0;
            off_b     = '0;
            err_term  = '0;
            err_inc_a = '0;
            err_inc_b = '0;
            octant    = '0;
            pixels_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.col     = i_m_tdata[7:0];
                seen.row     = i_m_tdata[15:8];
                seen.op      = i_m_tdata[17:16];
                seen.visible = i_m_tuser;
                seen.last_px = i_m_tlast;
                if (pixels_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected pixel beat x=%0d y=%0d vis=%0b op=%0d last=%0b",
                                 $realtime, seen.col, seen.row, seen.visible, seen.op,
                                 seen.last_px);
                end else begin
                    due = pixels_due.pop_front();
                    if (seen.col !== due.col || seen.row !== due.row ||
                        seen.visible !== due.visible || seen.op !== due.op ||
                        seen.last_px !== due.last_px) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: pixel mismatch, expected x=%0d y=%0d vis=%0b ",
                                      "op=%0d last=%0b, got x=%0d y=%0d vis=%0b op=%0d last=%0b"},
                                     $realtime, due.col, due.row, due.visible, due.op,
                                     due.last_px, seen.col, seen.row, seen.visible, seen.op,
                                     seen.last_px);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                rasterize_beat(t_cmd'(i_s_tuser), i_s_tdata);
        end
        o_fail_count <= mismatches;
        o_pending    <= pixels_due.size();
    end

endmodule

### verif/tb_circle_rasterizer_unit.sv
// Testbench top for the circle rasterizer unit: clock, reset, stimulus and
// random back-pressure; checking is done by cru_checker.
// Depends on cru_pkg, cru_checker and circle_rasterizer_unit.
module tb_circle_rasterizer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cru_pkg::*;

    localparam int RUN_ITEMS    = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = CMD_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int send_idle_pct  = 36;
    int recv_idle_pct  = 47;
    int circles_closed = 0;
    int items_counted  = 0;
    int cycle_count    = 0;

    circle_rasterizer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cru_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Completed circles, seen as last-pixel beats
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            circles_closed <= circles_closed + 1;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One input beat, with random idle cycles in front; returns once accepted
    task automatic send_beat(input t_cmd cmd, input logic [7:0] col, input logic [7:0] row,
                             input logic [6:0] rad, input logic [1:0] op);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, op, rad, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Advance beat; the other fields carry junk that must be ignored
    task automatic advance_beat();
        logic [24:0] junk;
        junk = 25'($urandom);
        send_beat(CMD_ADVANCE, junk[7:0], junk[15:8], junk[22:16], junk[24:23]);
    endtask

    // Hold the input idle until every predicted pixel has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly small circles, a few mid-size, rarely a big one
    function automatic logic [6:0] pick_radius();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return 7'($urandom_range(15));
        else if (roll < 97)
            return 7'($urandom_range(63, 16));
        return 7'($urandom_range(127, 64));
    endfunction

    // Start a circle, then advance to the end or abandon it early
    task automatic draw_circle(input logic [6:0] rad, input bit run_out);
        int closed_before;
        int cut;
        int sent;
        closed_before = circles_closed;
        // cut stays below the pixel count, so an abandoned circle never ends
        cut = $urandom_range(7 + 8 * ((int'(rad) * 2) / 3), 1);
        send_beat(CMD_START, 8'($urandom), 8'($urandom), rad, 2'($urandom));
        items_counted++;
        sent = 0;
        while (circles_closed == closed_before && (run_out || sent < cut)) begin
            advance_beat();
            sent++;
            items_counted++;
        end
    endtask

    initial begin
        int  phase;
        bit  run_out;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: advance while idle
        advance_beat();
        // zero radius at the top corner: eight centre pixels, then idle again
        send_beat(CMD_START, 8'd255, 8'd255, 7'd0, 2'd3);
        repeat (8) advance_beat();
        advance_beat();
        // largest radius at the origin, wrapping below zero, then restarted
        send_beat(CMD_START, 8'd0, 8'd0, 7'd127, 2'd0);
        repeat (3) advance_beat();
        // start while busy, on the screen edge
        send_beat(CMD_START, 8'd127, 8'd63, 7'd0, 2'd1);
        repeat (8) advance_beat();
        items_counted = 24;

        // Random circles across three back-pressure phases
        phase = 0;
        while (items_counted < RUN_ITEMS) begin
            if (phase == 0 && items_counted >= RUN_ITEMS / 3) begin
                wait_drained();
                phase = 1;
                send_idle_pct = 47;
                recv_idle_pct = 36;
            end else if (phase == 1 && items_counted >= (2 * RUN_ITEMS) / 3) begin
                wait_drained();
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_out = ($urandom_range(99) < 80);
            draw_circle(pick_radius(), run_out);
            // stray advances while idle
            if (run_out && $urandom_range(99) < 15)
                repeat ($urandom_range(4, 1)) begin
                    advance_beat();
                    items_counted++;
                end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
